// ===== hw/rtl/median_filter_3x3_cross_unit_assert.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_CROSS_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_3X3_CROSS_UNIT_ASSERT_SVH

`ifndef SYNTH
`define MF3X_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("median filter check failed");
`define MF3X_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("median filter check failed");
`define MF3X_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("median filter check failed");
`else
`define MF3X_ASSERT(lbl, expr)
`define MF3X_ASSERT_IMP(lbl, ante, cons)
`define MF3X_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/mf3x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mf3x_pkg;

  localparam int PORT_BITS = 8;
  localparam int WIN_N     = 9;
  localparam int WIN_DIM   = 3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic ACT_FLUSH = 1'b1;
  localparam logic MODE_FULL = 1'b1;

  // Window index is row * 3 + column; the cross uses N, W, centre, E and S.
  localparam logic [WIN_N-1:0] CROSS_SET  = 9'b010111010;
  localparam logic [3:0]       RANK_CROSS = 4'd2;
  localparam logic [3:0]       RANK_FULL  = 4'd4;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic top_zero;
    logic bottom_zero;
    logic left_zero;
    logic right_zero;
  } mask_t;

  typedef struct packed {
    logic [PORT_BITS-1:0] pixel;
    logic                 row_end;
    logic                 frame_end;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mf3x_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mf3x_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3x_median #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [PIXEL_BITS-1:0] in_vals [mf3x_pkg::WIN_N],
  input  wire logic                  in_mode,
  input  wire mf3x_pkg::tag_t        in_tag,
  output logic                       out_valid,
  output mf3x_pkg::result_t          out_result
);

  `include "median_filter_3x3_cross_unit_assert.svh"

  localparam int N = mf3x_pkg::WIN_N;

  logic [N-1:0]          set_sel;
  logic [3:0]            rank_sel;
  logic [N-1:0]          lt [N];

  logic                  a_valid_r;
  logic [PIXEL_BITS-1:0] a_vals_r [N];
  logic [N-1:0]          a_lt_r [N];
  logic [N-1:0]          a_set_r;
  logic [3:0]            a_rank_r;
  mf3x_pkg::tag_t        a_tag_r;

  logic [N-1:0]          hit;
  logic [PIXEL_BITS-1:0] sel;
  mf3x_pkg::result_t     b_result_nxt;
  mf3x_pkg::result_t     b_result_r;
  logic                  b_valid_r;

  // Each value's rank is the number of set members below it, ties broken by index.
  always_comb begin
    set_sel  = (in_mode == mf3x_pkg::MODE_FULL) ? {N{1'b1}} : mf3x_pkg::CROSS_SET;
    rank_sel = (in_mode == mf3x_pkg::MODE_FULL) ? mf3x_pkg::RANK_FULL : mf3x_pkg::RANK_CROSS;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt[i][j] = set_sel[j] && ((in_vals[j] < in_vals[i]) ||
                   ((in_vals[j] == in_vals[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vals_r <= in_vals;
      a_lt_r   <= lt;
      a_set_r  <= set_sel;
      a_rank_r <= rank_sel;
      a_tag_r  <= in_tag;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < N; i++) begin
      hit[i] = a_set_r[i] && (4'($countones(a_lt_r[i])) == a_rank_r);
      if (hit[i]) begin
        sel = sel | a_vals_r[i];
      end
    end
    b_result_nxt.pixel     = mf3x_pkg::PORT_BITS'(sel);
    b_result_nxt.row_end   = a_tag_r.row_end;
    b_result_nxt.frame_end = a_tag_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_result_r <= b_result_nxt;
    end
  end

  assign out_valid  = b_valid_r;
  assign out_result = b_result_r;

  `MF3X_ASSERT_IMP(a_unique_rank, a_valid_r, $onehot(hit))

endmodule

`default_nettype wire

// ===== hw/rtl/mf3x_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3x_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mf3x_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mf3x_pkg::result_t      out_data
);

  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  mf3x_pkg::result_t slot0_r;
  mf3x_pkg::result_t slot0_nxt;
  mf3x_pkg::result_t slot1_r;
  mf3x_pkg::result_t slot1_nxt;
  logic              pop;

  assign pop = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case ({push, pop})
      2'b10: begin
        count_nxt = count_r + 2'd1;
        if (count_r == 2'd0) begin
          slot0_nxt = push_data;
        end else begin
          slot1_nxt = push_data;
        end
      end
      2'b01: begin
        count_nxt = count_r - 2'd1;
        slot0_nxt = slot1_r;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;

endmodule

`default_nettype wire

// ===== hw/rtl/median_filter_3x3_cross_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 median filter with zero padding. Pixels enter in raster order, one per
// transaction, and one filtered pixel leaves for each image position, one row plus one
// pixel behind the input; after a frame the driver sends flush transactions to drain it.
// The block takes one transaction per clock for as long as results are taken: the line
// store is a single-port-write RAM with one entry per column holding the two rows above,
// read when a pixel is taken and written back when the pipeline next advances, with
// the write data forwarded when consecutive pixels hit the same column. A result is
// offered after the transaction completing its window passes the line store read, rank
// compare and select registers and the output queue, where up to two results wait. The
// line store needs no clearing pass after reset, as every entry that reaches a result has
// been written in this frame. Width, height and mode writes restart the frame position.

module median_filter_3x3_cross_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_pixel_in,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_pixel_out,
  output logic             out_row_end,
  output logic             out_frame_end
);

  `include "median_filter_3x3_cross_unit_assert.svh"

  localparam int P  = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int N  = mf3x_pkg::WIN_N;
  localparam int D  = mf3x_pkg::WIN_DIM;

  logic [10:0]       cfg_width_r;
  logic [15:0]       cfg_height_r;
  logic              cfg_mode_r;
  logic              cfg_restart;

  logic [WW-1:0]     w_eff;
  logic [15:0]       h_eff;

  logic [CW-1:0]     in_col_r;
  logic [CW-1:0]     in_col_nxt;
  logic [16:0]       in_row_r;
  logic [16:0]       in_row_nxt;
  logic [CW-1:0]     out_col_r;
  logic [CW-1:0]     out_col_nxt;
  logic [15:0]       out_row_r;
  logic [15:0]       out_row_nxt;

  logic              en;
  logic              flushing;
  logic              ignore;
  logic              take;
  logic [P-1:0]      px;
  logic [CW-1:0]     ic;
  logic              emit;
  logic              col_last_in;
  logic              ocol_last;
  logic              orow_last;
  logic              last;
  mf3x_pkg::mask_t   mask;
  mf3x_pkg::tag_t    tag;

  logic              s1_valid_r;
  logic [P-1:0]      s1_px_r;
  logic [CW-1:0]     s1_ic_r;
  logic              s1_emit_r;
  mf3x_pkg::mask_t   s1_mask_r;
  mf3x_pkg::tag_t    s1_tag_r;

  logic              fwd_hit_r;
  logic [2*P-1:0]    fwd_data_r;
  logic [2*P-1:0]    ram_rdata;
  logic [2*P-1:0]    rd;
  logic [2*P-1:0]    wr_data;
  logic [P-1:0]      above2;
  logic [P-1:0]      above1;

  logic [P-1:0]      window_r [N];
  logic [P-1:0]      window_nxt [N];
  logic [P-1:0]      win_vals [N];

  logic              med_valid;
  mf3x_pkg::result_t med_result;
  logic              q_full;
  mf3x_pkg::result_t q_data;

  // Configuration registers.
  assign cfg_restart = cfg_wr_en && (cfg_index inside {mf3x_pkg::REG_WIDTH,
                       mf3x_pkg::REG_HEIGHT, mf3x_pkg::REG_MODE});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 11'd1024;
      cfg_height_r <= 16'd1;
      cfg_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mf3x_pkg::REG_WIDTH:  cfg_width_r  <= cfg_wdata[10:0];
        mf3x_pkg::REG_HEIGHT: cfg_height_r <= cfg_wdata;
        mf3x_pkg::REG_MODE:   cfg_mode_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    h_eff = (cfg_height_r == 16'd0) ? 16'd1 : cfg_height_r;
  end

  // Stage 0: position bookkeeping and line store read.
  assign en       = !q_full;
  assign in_ready = en;

  assign flushing    = in_row_r >= {1'b0, h_eff};
  assign ignore      = !flushing && (in_action == mf3x_pkg::ACT_FLUSH);
  assign take        = in_valid && in_ready && !ignore;
  assign px          = flushing ? '0 : P'(in_pixel_in);
  assign ic          = ({1'b0, in_col_r} >= w_eff) ? '0 : in_col_r;
  assign emit        = (in_row_r >= 17'd2) || ((in_row_r == 17'd1) && (ic != '0));
  assign col_last_in = (WW'(ic) + WW'(1)) >= w_eff;
  assign ocol_last   = (WW'(out_col_r) + WW'(1)) >= w_eff;
  assign orow_last   = ({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff};
  assign last        = ocol_last && orow_last;

  assign mask.top_zero    = (out_row_r == 16'd0);
  assign mask.bottom_zero = orow_last;
  assign mask.left_zero   = (out_col_r == '0);
  assign mask.right_zero  = ocol_last;
  assign tag.row_end      = ocol_last;
  assign tag.frame_end    = last;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (col_last_in) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 17'd1;
      end else begin
        in_col_nxt = ic + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 16'd1;
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r <= take;
      if (take) begin
        fwd_hit_r <= s1_valid_r && (s1_ic_r == ic);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px_r    <= px;
      s1_ic_r    <= ic;
      s1_emit_r  <= emit;
      s1_mask_r  <= mask;
      s1_tag_r   <= tag;
      fwd_data_r <= wr_data;
    end
  end

  mf3x_ram #(
    .WIDTH (2 * P),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (en && s1_valid_r),
    .waddr (s1_ic_r),
    .wdata (wr_data),
    .re    (take),
    .raddr (ic),
    .rdata (ram_rdata)
  );

  // Stage 1: write back the column, shift the window and mask the borders.
  assign rd      = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign above2  = rd[2*P-1:P];
  assign above1  = rd[P-1:0];
  assign wr_data = {above1, s1_px_r};

  always_comb begin
    for (int r = 0; r < D; r++) begin
      window_nxt[r*D]     = window_r[r*D+1];
      window_nxt[r*D + 1] = window_r[r*D+2];
    end
    window_nxt[2] = above2;
    window_nxt[5] = above1;
    window_nxt[8] = s1_px_r;
    for (int r = 0; r < D; r++) begin
      for (int c = 0; c < D; c++) begin
        if ((r == 0 && s1_mask_r.top_zero) || (r == D-1 && s1_mask_r.bottom_zero) ||
            (c == 0 && s1_mask_r.left_zero) || (c == D-1 && s1_mask_r.right_zero)) begin
          win_vals[r*D+c] = '0;
        end else begin
          win_vals[r*D+c] = window_nxt[r*D+c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        window_r[k] <= '0;
      end
    end else if (en && s1_valid_r) begin
      window_r <= window_nxt;
    end
  end

  mf3x_median #(
    .PIXEL_BITS (P)
  ) u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s1_valid_r && s1_emit_r),
    .in_vals    (win_vals),
    .in_mode    (cfg_mode_r),
    .in_tag     (s1_tag_r),
    .out_valid  (med_valid),
    .out_result (med_result)
  );

  mf3x_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en && med_valid),
    .push_data (med_result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_pixel_out = q_data.pixel;
  assign out_row_end   = q_data.row_end;
  assign out_frame_end = q_data.frame_end;

  `MF3X_ASSERT(a_in_col_range, {1'b0, in_col_r} < w_eff)
  `MF3X_ASSERT(a_out_behind_in, {1'b0, out_row_r} <= in_row_r)
  `MF3X_ASSERT_NEXT(a_stall_holds_s1, !en && s1_valid_r, s1_valid_r && $stable(s1_ic_r))

endmodule

`default_nettype wire

// ===== verif/mf3x_median_checker.sv =====
`timescale 1ns / 1ps

module mf3x_median_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_pixel_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_pixel_out,
  input  logic        out_row_end,
  input  logic        out_frame_end,
  output int          mismatches,
  output int          awaiting
);
  import mf3x_pkg::*;

  int              width_reg;
  int              height_reg;
  logic            full_window;
  logic [7:0]      row_far [MAX_WIDTH];
  logic [7:0]      row_near [MAX_WIDTH];
  logic [8:0][7:0] window;
  int              feed_col, feed_row, emit_col, emit_row;
  result_t         filtered_px [$];
  result_t         want_px, seen_px;

  task automatic restart_position();
    feed_col = 0;
    feed_row = 0;
    emit_col = 0;
    emit_row = 0;
  endtask

  function automatic logic [7:0] middle_value(input logic [8:0][7:0] vals, input int count);
    int below, not_above;
    logic [7:0] pick;
    pick = '0;
    for (int i = 0; i < count; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < count; j++) begin
        if (vals[j] < vals[i]) below++;
        if (vals[j] <= vals[i]) not_above++;
      end
      if (below <= count / 2 && not_above > count / 2) pick = vals[i];
    end
    return pick;
  endfunction

  task automatic filter_item(input logic act, input logic [7:0] pix);
    int w, h, col, row;
    logic [7:0] px, far_px, near_px;
    logic [8:0][7:0] masked, cross_vals;
    logic last_col, last_px, blank;
    result_t res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    if (feed_row < h && act == ACT_FLUSH) return;
    px = (feed_row >= h) ? 8'd0 : pix;
    col = (feed_col >= w) ? 0 : feed_col;
    row = feed_row;
    far_px = row_far[col];
    near_px = row_near[col];
    row_far[col] = near_px;
    row_near[col] = px;
    for (int r = 0; r < 3; r++) begin
      window[r * 3] = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = far_px;
    window[5] = near_px;
    window[8] = px;
    if (col + 1 >= w) begin
      feed_col = 0;
      feed_row = row + 1;
    end else begin
      feed_col = col + 1;
    end
    if (!(row >= 2 || (row == 1 && col >= 1))) return;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        blank = (r == 0 && emit_row == 0) || (r == 2 && emit_row + 1 >= h) ||
                (c == 0 && emit_col == 0) || (c == 2 && emit_col + 1 >= w);
        masked[r * 3 + c] = blank ? 8'd0 : window[r * 3 + c];
      end
    end
    if (full_window) begin
      res.pixel = middle_value(masked, 9);
    end else begin
      cross_vals = '0;
      cross_vals[0] = masked[4];
      cross_vals[1] = masked[1];
      cross_vals[2] = masked[7];
      cross_vals[3] = masked[3];
      cross_vals[4] = masked[5];
      res.pixel = middle_value(cross_vals, 5);
    end
    last_col = emit_col + 1 >= w;
    last_px = last_col && emit_row + 1 >= h;
    res.row_end = last_col;
    res.frame_end = last_px;
    filtered_px.push_back(res);
    if (last_px) begin
      restart_position();
    end else if (last_col) begin
      emit_col = 0;
      emit_row++;
    end else begin
      emit_col++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 1024;
      height_reg = 1;
      full_window = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_far[i] = '0;
        row_near[i] = '0;
      end
      window = '0;
      restart_position();
      filtered_px.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_px.pixel = out_pixel_out;
        seen_px.row_end = out_row_end;
        seen_px.frame_end = out_frame_end;
        if (filtered_px.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, actual pixel %0d row_end %0b frame_end %0b",
                   $time, seen_px.pixel, seen_px.row_end, seen_px.frame_end);
        end else begin
          want_px = filtered_px.pop_front();
          if (seen_px !== want_px) begin
            mismatches++;
            $display("%0t: expected pixel %0d row_end %0b frame_end %0b, actual %0d %0b %0b",
                     $time, want_px.pixel, want_px.row_end, want_px.frame_end,
                     seen_px.pixel, seen_px.row_end, seen_px.frame_end);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_reg = cfg_wdata[10:0];
            restart_position();
          end
          REG_HEIGHT: begin
            height_reg = cfg_wdata;
            restart_position();
          end
          REG_MODE: begin
            full_window = (cfg_wdata[0] == MODE_FULL);
            restart_position();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_item(in_action, in_pixel_in);
    end
    awaiting = filtered_px.size();
  end

endmodule

// ===== verif/tb_median_filter_3x3_cross_unit.sv =====
`timescale 1ns / 1ps

module tb_median_filter_3x3_cross_unit;
  import mf3x_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic       ACT_PIXEL = ~ACT_FLUSH;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_ITEMS = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [7:0]  in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  out_pixel_out;
  logic        out_row_end;
  logic        out_frame_end;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  int cur_w = 1024;
  int cur_h = 1;
  int mismatches;
  int awaiting;

  always #1 clk = ~clk;

  median_filter_3x3_cross_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end)
  );

  mf3x_median_checker median_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL median_filter_3x3_cross_unit");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_item(input logic act, input logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_pixel_in = pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic set_frame(input logic [10:0] raw_w, input logic [15:0] raw_h,
                           input logic mode);
    write_reg(REG_WIDTH, 16'($urandom & 32'hF800) | {5'd0, raw_w});
    write_reg(REG_HEIGHT, raw_h);
    write_reg(REG_MODE, 16'($urandom & 32'hFFFE) | {15'd0, mode});
    cur_w = (raw_w == 0) ? 1 : (raw_w > 1024) ? 1024 : raw_w;
    cur_h = (raw_h == 0) ? 1 : raw_h;
  endtask

  task automatic play_frame(input bit abandon, input bit hold);
    int total, stop;
    total = cur_w * cur_h;
    stop = abandon ? $urandom_range(1, total) : total;
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(9) == 0) send_item(ACT_FLUSH, 8'($urandom));
      if (hold && i == stop / 2) settle();
      send_item(ACT_PIXEL, pick_pixel());
      sent++;
    end
    if (!abandon) begin
      for (int i = 0; i <= cur_w; i++) begin
        send_item($urandom_range(1) ? ACT_FLUSH : ACT_PIXEL, 8'($urandom));
        sent++;
      end
    end
    settle();
  endtask

  // Sends the first pixels of a large frame and leaves it unfinished.
  task automatic play_start(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(ACT_PIXEL, pick_pixel());
      sent++;
    end
    settle();
  endtask

  initial begin
    int target;
    int raw_w;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Zero width and height both behave as one; the unused index is ignored.
    set_frame(11'd0, 16'd0, 1'b0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_PIXEL, 8'd77);
    settle();

    // A flush inside the frame is ignored, and pixels after the frame act as flushes.
    set_frame(11'd2, 16'd2, MODE_FULL);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd1);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_PIXEL, 8'd200);
    settle();

    // A frame cut short by a register write starts over from the top left.
    set_frame(11'd3, 16'd3, 1'b0);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd128);
    send_item(ACT_PIXEL, 8'd255);
    settle();
    set_frame(11'd3, 16'd2, 1'b0);
    play_frame(1'b0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      target = sent + RANDOM_ITEMS / 4;
      while (sent < target) begin
        case ($urandom_range(19))
          0: raw_w = 0;
          1: raw_w = $urandom_range(11, 24);
          default: raw_w = $urandom_range(1, 8);
        endcase
        set_frame(11'(raw_w), 16'($urandom_range(0, 6)), 1'($urandom_range(1)));
        play_frame($urandom_range(9) == 0, $urandom_range(3) == 0);
      end
      if (phase == 0) begin
        set_frame(11'd2047, 16'd3, MODE_FULL);
        play_start(48);
        set_frame(11'd1, 16'hFFFF, MODE_FULL);
        play_start(48);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS median_filter_3x3_cross_unit");
    end else begin
      $display("FAIL median_filter_3x3_cross_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mf3x_pkg.sv
hw/rtl/mf3x_ram.sv
hw/rtl/mf3x_median.sv
hw/rtl/mf3x_outq.sv
hw/rtl/median_filter_3x3_cross_unit.sv
verif/mf3x_median_checker.sv
verif/tb_median_filter_3x3_cross_unit.sv
